@@ hdl/fcwd_pkg.sv @@
package fcwd_pkg;

    localparam int unsigned ADDR_W = 25;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned WIDTH_W = 3;
    localparam int unsigned BLOCKS_W = 4;

    localparam int unsigned NOR_WINDOW_OFFSET = 16777216;
    localparam int unsigned DATA_WINDOW_OFFSET = 31457280;
    localparam int unsigned MAX_BLOCKS = 8;

    localparam logic [ADDR_W-1:0] NOR_WIN_BASE = ADDR_W'(NOR_WINDOW_OFFSET);
    localparam logic [ADDR_W-1:0] DATA_WIN_BASE = ADDR_W'(DATA_WINDOW_OFFSET);

    localparam logic [ADDR_W-1:0] A_CTRL = 25'h1400000;
    localparam logic [ADDR_W-1:0] A_BUFCTRL = 25'h1420000;
    localparam logic [ADDR_W-1:0] A_LBA_LO = 25'h1600000;
    localparam logic [ADDR_W-1:0] A_LBA_HI = 25'h1620000;
    localparam logic [ADDR_W-1:0] A_COUNT = 25'h1640000;
    localparam logic [ADDR_W-1:0] A_SPICTRL = 25'h1660000;
    localparam logic [ADDR_W-1:0] A_SPIWR = 25'h1680000;
    localparam logic [ADDR_W-1:0] A_RTC = 25'h16A0000;
    localparam logic [ADDR_W-1:0] A_PSRAMPG = 25'h1860000;
    localparam logic [ADDR_W-1:0] A_ROMPG = 25'h1880000;
    localparam logic [ADDR_W-1:0] A_RAMPG = 25'h1C00000;
    localparam logic [ADDR_W-1:0] A_COMMIT0 = 25'h1FC0000;
    localparam logic [ADDR_W-1:0] A_COMMIT1 = 25'h1FE0000;
    localparam logic [ADDR_W-1:0] NOR_LO = 25'h1000000;
    localparam logic [ADDR_W-1:0] NOR_HI = 25'h1800000;
    localparam logic [ADDR_W-1:0] WIN_LO = 25'h1E00000;
    localparam logic [ADDR_W-1:0] WIN_HI = 25'h1E80000;

    localparam logic [ADDR_W-1:0] ID_WORD_OFFSET = 25'h000001C;
    localparam logic [ADDR_W-1:0] ERASE_SECTOR_MASK = 25'h1FE0000;

    localparam logic [11:0] CMD_ADDR_AAA = 12'hAAA;
    localparam logic [11:0] CMD_ADDR_554 = 12'h554;

    localparam logic [HALF_W-1:0] CMD_UNLOCK1 = 16'h00AA;
    localparam logic [HALF_W-1:0] CMD_UNLOCK2 = 16'h0055;
    localparam logic [HALF_W-1:0] CMD_ERASE_CONFIRM = 16'h0030;
    localparam logic [HALF_W-1:0] CMD_ERASE_SETUP = 16'h0080;
    localparam logic [HALF_W-1:0] CMD_PROGRAM = 16'h00A0;
    localparam logic [HALF_W-1:0] CMD_ID_ENTRY = 16'h0090;
    localparam logic [HALF_W-1:0] CMD_RESET = 16'h00F0;

    localparam logic [HALF_W-1:0] CTRL_READ_POLL = 16'h0003;
    localparam logic [HALF_W-1:0] CTRL_WRITE_GO = 16'h0001;
    localparam logic [HALF_W-1:0] SPI_ENABLE = 16'h0001;

    localparam logic [HALF_W-1:0] ID_WORD = 16'h223D;
    localparam logic [HALF_W-1:0] ID_EXIT_WORD = 16'hFFFF;
    localparam logic [HALF_W-1:0] SPI_STATUS_WORD = 16'hC003;

    localparam logic [1:0] UNLOCK_IDLE = 2'd0;
    localparam logic [1:0] UNLOCK_FIRST = 2'd1;
    localparam logic [1:0] UNLOCK_SECOND = 2'd2;

    localparam int unsigned WIDTH_WORD = 4;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_HW = 3'd1,
        OP_ERASE = 3'd2,
        OP_CREAD = 3'd3,
        OP_CWRITE = 3'd4,
        OP_CLEAR = 3'd5
    } store_op_t;

    typedef struct packed {
        logic consumed;
        store_op_t store_op;
        logic [ADDR_W-1:0] store_addr;
        logic [HALF_W-1:0] store_data;
        logic [DATA_W-1:0] card_block_addr;
        logic [BLOCKS_W-1:0] card_blocks;
        logic last;
    } result_t;

    typedef struct packed {
        logic [DATA_W-1:0] block_address;
        logic [HALF_W-1:0] block_count_raw;
        logic read_pending;
        logic write_pending;
        logic [1:0] unlock_stage;
        logic id_mode;
        logic erase_armed;
        logic program_armed;
    } dec_state_t;

endpackage

@@ hdl/flash_cart_write_decoder.sv @@
// Write decoder for a flash cartridge with an SD card bridge and a NOR command interface.
// Bus writes enter on the s_ channel, one transaction per access, and every access yields
// one result on the m_ channel, or two for a 32-bit write to the data window (m_tlast
// marks the final one). Each result says whether the write was swallowed and which
// operation, if any, the backing store must carry out.
// A transaction is registered in the input register on acceptance and decoded there; its
// results enter a three-entry output queue once it has room, and the queue head is offered
// on the m_ channel. One access can be accepted in every cycle while the queue has room;
// the output channel, which moves one result a cycle while m_tready is high, sets the
// sustained rate, so a 32-bit data window write uses it for both of its results.
// When the receiver stalls, results wait in the queue and the input register; s_tready
// falls once they hold no room for a further access's results, and nothing is dropped.
// The card_present register is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while the block is idle (not enforced). Reset clears it, the block
// address, block count, pending flags and all NOR command state, and empties the queue.
module flash_cart_write_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // bus_addr[24:0], bus_data[56:25], zero padding
    input  logic [2:0]  s_tuser,   // access_width[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // consumed[0], store_addr[25:1], store_data[41:26],
                                   // card_block_addr[73:42], card_blocks[77:74], padding
    output logic [2:0]  m_tuser,   // store_op[2:0]
    output logic        m_tlast
);
    import fcwd_pkg::*;

    localparam int unsigned QDEPTH = 3;

    logic card_present_reg;
    dec_state_t state_reg;
    dec_state_t state_next;

    logic in_valid_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic [WIDTH_W-1:0] in_width_reg;

    result_t res0;
    result_t res1;
    logic two_results;

    result_t q_reg [QDEPTH];
    result_t q_next [QDEPTH];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] base;
    logic pop;
    logic in_advance;

    fcwd_decode u_decode (
        .bus_addr     (in_addr_reg),
        .bus_data     (in_data_reg),
        .access_width (in_width_reg),
        .card_present (card_present_reg),
        .state_cur    (state_reg),
        .state_next   (state_next),
        .res0         (res0),
        .res1         (res1),
        .two_results  (two_results)
    );

    assign pop = m_tvalid && m_tready;
    assign base = count_reg - {1'b0, pop};
    assign in_advance = in_valid_reg && (base <= 2'd1);
    assign s_tready = !in_valid_reg || in_advance;

    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && i < QDEPTH - 1) begin
                q_next[i] = q_reg[i + 1];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (in_advance && base == 2'(i)) begin
                q_next[i] = res0;
            end
            if (in_advance && two_results && (base + 2'd1) == 2'(i)) begin
                q_next[i] = res1;
            end
        end
        count_next = base + {1'b0, in_advance} + {1'b0, in_advance && two_results};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            card_present_reg <= 1'b0;
            state_reg <= '0;
            in_valid_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                card_present_reg <= cfg_wr_data;
            end
            if (in_advance) begin
                state_reg <= state_next;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_addr_reg <= s_tdata[24:0];
            in_data_reg <= s_tdata[56:25];
            in_width_reg <= s_tuser;
        end
        for (int i = 0; i < QDEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata = {2'b00, q_reg[0].card_blocks, q_reg[0].card_block_addr,
                      q_reg[0].store_data, q_reg[0].store_addr, q_reg[0].consumed};
    assign m_tuser = q_reg[0].store_op;
    assign m_tlast = q_reg[0].last;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(QDEPTH))
        else $error("Result queue holds more entries than it has.");

    a_pair_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (count_reg >= 2'd2))
        else $error("First half of a word write is offered without its second half queued.");

    a_blocks_only_card: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != OP_CREAD && m_tuser != OP_CWRITE) |-> (m_tdata[77:74] == 4'd0))
        else $error("Block count is set on a result that is not a card transfer.");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_advance) |=> in_valid_reg)
        else $error("A held access was lost from the input register.");

endmodule

@@ hdl/fcwd_decode.sv @@
module fcwd_decode (
    input  logic [fcwd_pkg::ADDR_W-1:0]  bus_addr,
    input  logic [fcwd_pkg::DATA_W-1:0]  bus_data,
    input  logic [fcwd_pkg::WIDTH_W-1:0] access_width,
    input  logic                         card_present,
    input  fcwd_pkg::dec_state_t         state_cur,
    output fcwd_pkg::dec_state_t         state_next,
    output fcwd_pkg::result_t            res0,
    output fcwd_pkg::result_t            res1,
    output logic                         two_results
);
    import fcwd_pkg::*;

    logic [HALF_W-1:0] val;
    logic [ADDR_W-1:0] nor_soff;
    logic [ADDR_W-1:0] win_soff;
    logic [11:0] wo;
    logic [14:0] count_masked;
    logic [BLOCKS_W-1:0] blocks;
    logic in_nor;
    logic in_win;

    assign val = bus_data[HALF_W-1:0];
    assign nor_soff = NOR_WIN_BASE + (bus_addr - NOR_LO);
    assign win_soff = DATA_WIN_BASE + (bus_addr - WIN_LO);
    assign wo = bus_addr[11:0];
    assign count_masked = state_cur.block_count_raw[14:0];
    assign in_nor = (bus_addr >= NOR_LO) && (bus_addr < NOR_HI);
    assign in_win = (bus_addr >= WIN_LO) && (bus_addr < WIN_HI);

    always_comb begin
        if (count_masked == 15'd0) begin
            blocks = BLOCKS_W'(1);
        end else if (count_masked > 15'(MAX_BLOCKS)) begin
            blocks = BLOCKS_W'(MAX_BLOCKS);
        end else begin
            blocks = count_masked[BLOCKS_W-1:0];
        end
    end

    always_comb begin
        state_next = state_cur;
        two_results = 1'b0;
        res0 = '0;
        res0.consumed = 1'b1;
        res0.store_op = OP_NONE;
        res0.last = 1'b1;
        res1 = '0;
        res1.consumed = 1'b1;
        res1.store_op = OP_HW;
        res1.store_addr = win_soff + ADDR_W'(2);
        res1.store_data = bus_data[DATA_W-1:HALF_W];
        res1.last = 1'b1;

        priority if (bus_addr == A_LBA_LO) begin
            state_next.block_address[HALF_W-1:0] = val;
        end else if (bus_addr == A_LBA_HI) begin
            state_next.block_address[DATA_W-1:HALF_W] = val;
        end else if (bus_addr == A_COUNT) begin
            state_next.block_count_raw = val;
            if (val[15]) begin
                state_next.write_pending = 1'b1;
            end else begin
                state_next.read_pending = 1'b1;
            end
        end else if (bus_addr == A_CTRL) begin
            if (val == CTRL_READ_POLL) begin
                if (state_cur.read_pending) begin
                    state_next.read_pending = 1'b0;
                    res0.store_addr = DATA_WIN_BASE;
                    if (card_present) begin
                        res0.store_op = OP_CREAD;
                        res0.card_block_addr = state_cur.block_address;
                        res0.card_blocks = blocks;
                    end else begin
                        res0.store_op = OP_CLEAR;
                    end
                end else if (!state_cur.write_pending) begin
                    res0.store_op = OP_HW;
                    res0.store_addr = DATA_WIN_BASE;
                end
            end else if (val == CTRL_WRITE_GO) begin
                if (state_cur.write_pending) begin
                    state_next.write_pending = 1'b0;
                    if (card_present) begin
                        res0.store_op = OP_CWRITE;
                        res0.store_addr = DATA_WIN_BASE;
                        res0.card_block_addr = state_cur.block_address;
                        res0.card_blocks = blocks;
                    end
                end
            end
        end else if (bus_addr == A_SPICTRL) begin
            if (val == SPI_ENABLE) begin
                res0.store_op = OP_HW;
                res0.store_addr = DATA_WIN_BASE;
                res0.store_data = SPI_STATUS_WORD;
            end
        end else if (bus_addr == A_SPIWR || bus_addr == A_ROMPG || bus_addr == A_PSRAMPG
                     || bus_addr == A_RAMPG || bus_addr == A_BUFCTRL || bus_addr == A_RTC) begin
            res0.consumed = 1'b1;
        end else if (in_nor) begin
            priority if (state_cur.program_armed) begin
                state_next.program_armed = 1'b0;
                res0.store_op = OP_HW;
                res0.store_addr = nor_soff;
                res0.store_data = val;
            end else if (state_cur.erase_armed && val == CMD_ERASE_CONFIRM) begin
                state_next.erase_armed = 1'b0;
                state_next.unlock_stage = UNLOCK_IDLE;
                res0.store_op = OP_ERASE;
                res0.store_addr = nor_soff & ERASE_SECTOR_MASK;
            end else if (wo == CMD_ADDR_AAA && val == CMD_UNLOCK1) begin
                state_next.unlock_stage = UNLOCK_FIRST;
            end else if (wo == CMD_ADDR_554 && val == CMD_UNLOCK2
                         && state_cur.unlock_stage == UNLOCK_FIRST) begin
                state_next.unlock_stage = UNLOCK_SECOND;
            end else if (wo == CMD_ADDR_AAA && state_cur.unlock_stage == UNLOCK_SECOND) begin
                state_next.unlock_stage = UNLOCK_IDLE;
                if (val == CMD_ERASE_SETUP) begin
                    state_next.erase_armed = 1'b1;
                end else if (val == CMD_PROGRAM) begin
                    state_next.program_armed = 1'b1;
                end else if (val == CMD_ID_ENTRY) begin
                    state_next.id_mode = 1'b1;
                    res0.store_op = OP_HW;
                    res0.store_addr = NOR_WIN_BASE + ID_WORD_OFFSET;
                    res0.store_data = ID_WORD;
                end
            end else if (val == CMD_RESET) begin
                if (state_cur.id_mode) begin
                    state_next.id_mode = 1'b0;
                    res0.store_op = OP_HW;
                    res0.store_addr = NOR_WIN_BASE + ID_WORD_OFFSET;
                    res0.store_data = ID_EXIT_WORD;
                end
                state_next.unlock_stage = UNLOCK_IDLE;
                state_next.erase_armed = 1'b0;
                state_next.program_armed = 1'b0;
            end else begin
                state_next.unlock_stage = UNLOCK_IDLE;
            end
        end else if (in_win) begin
            res0.store_op = OP_HW;
            res0.store_addr = win_soff;
            res0.store_data = val;
            if (access_width == WIDTH_W'(WIDTH_WORD)) begin
                res0.last = 1'b0;
                two_results = 1'b1;
            end
        end else if (bus_addr < NOR_LO || bus_addr == A_COMMIT0 || bus_addr == A_COMMIT1) begin
            res0.consumed = 1'b1;
        end else begin
            res0.consumed = 1'b0;
        end
    end

endmodule
